### hw/rtl/periodic_task_tick_scheduler_core_assert.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; include inside files that carry concurrent checks.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH

// Plain property check, disabled during reset.
`define PTTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Implication check: pre holds -> post holds in the same cycle.
`define PTTS_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

### hw/rtl/ptts_pkg.sv
// Types and codes for the periodic task tick scheduler.
// No dependencies; imported by ptts_cell and the core top level.
package ptts_pkg;

  // Command opcodes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_SUSPEND = 3'd2;
  localparam logic [2:0] OP_RESUME  = 3'd3;
  localparam logic [2:0] OP_DELETE  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TAKEN = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  task_index;
    logic [15:0] period;
    logic [15:0] first_delay;
    logic        handler_present;
  } cmd_item_t;

  typedef struct packed {
    logic       fired;
    logic [2:0] fired_task;
    logic [1:0] status;
    logic       last;
  } rpt_item_t;

  // Command as seen by one slot cell
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] period;
    logic [15:0] delay;
    logic        handler;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } scan_state_t;

endpackage

### hw/rtl/ptts_cell.sv
// One task slot of the scheduler chain: used/active marks, period, countdown.
// Depends on ptts_pkg. The scan token arrives from the previous cell.
module ptts_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              token_prev,
  output logic              token,
  input  logic              cmd_en,
  input  ptts_pkg::cell_cmd_t cmd,
  output logic              used,
  output logic              fire
);
  import ptts_pkg::*;

  logic        active;
  logic [15:0] period;
  logic [15:0] countdown;
  logic        visit;

  assign visit = token && step;
  assign fire  = token && active && used && (countdown == 16'd0);

  // Token shift: the scan position moves one cell per step
  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else if (step) begin
      token <= token_prev;
    end
  end

  // Slot state: updated by the scan visit or by a command for this slot
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= 1'b0;
      active    <= 1'b0;
      countdown <= 16'd0;
    end else if (visit) begin
      if (active) begin
        if (countdown == 16'd0) begin
          if (used) begin
            countdown <= period - 16'd1;
          end
        end else begin
          countdown <= countdown - 16'd1;
        end
      end
    end else if (cmd_en) begin
      case (cmd.op)
        OP_CREATE: begin
          if (!used) begin
            used      <= cmd.handler;
            active    <= 1'b1;
            countdown <= cmd.delay;
          end
        end
        OP_SUSPEND: active <= 1'b0;
        OP_RESUME:  active <= 1'b1;
        OP_DELETE:  used   <= 1'b0;
        default: ;
      endcase
    end
  end

  // Period store, written only by a create on a free slot
  always_ff @(posedge clk) begin
    if (!visit && cmd_en && cmd.op == OP_CREATE && !used) begin
      period <= cmd.period;
    end
  end

endmodule

### hw/rtl/periodic_task_tick_scheduler_core.sv
// Periodic task tick scheduler: every command other than a tick gives one result.
// A tick walks a scan token down the row of TASK_COUNT slot cells, one cell per
// cycle, and holds the block until the walk and its final result are done; the
// scan pauses whenever a result cannot be handed off.
// Fired slots are reported in ascending order, the final result of every input
// carries last; a tick with no firing yields one result with fired low.
// Depends on ptts_pkg, ptts_cell and periodic_task_tick_scheduler_core_assert.svh.
`include "periodic_task_tick_scheduler_core_assert.svh"

module periodic_task_tick_scheduler_core #(
  parameter int TASK_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ptts_pkg::cmd_item_t cmd,
  output logic                rpt_valid,
  input  logic                rpt_stall,
  output ptts_pkg::rpt_item_t rpt
);
  import ptts_pkg::*;

  localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  scan_state_t state;
  scan_state_t state_next;

  logic [TASK_COUNT-1:0] token_vec;
  logic [TASK_COUNT-1:0] chain_in;
  logic [TASK_COUNT-1:0] used_vec;
  logic [TASK_COUNT-1:0] fire_vec;
  logic [TASK_COUNT-1:0] hit_vec;
  logic [TASK_COUNT-1:0] en_vec;
  logic [IW-1:0]         scan_idx;
  logic                  pend_valid;
  logic [2:0]            pend_idx;
  logic [2:0]            fire_task;

  logic      out_free;
  logic      cmd_go;
  logic      is_tick;
  logic      start;
  logic      adv;
  logic      step;
  logic      fire_hit;
  logic      idx_ok;
  logic      taken;
  logic      slot_op;
  logic      out_load;
  rpt_item_t out_next;
  cell_cmd_t cell_cmd;

  // Handshake and scan control
  assign out_free  = !rpt_valid || !rpt_stall;
  assign cmd_stall = !((state == S_IDLE) && out_free);
  assign cmd_go    = cmd_valid && !cmd_stall;
  assign is_tick   = (cmd.opcode == OP_TICK);
  assign start     = cmd_go && is_tick;
  assign adv       = (state == S_SCAN) && out_free;
  assign step      = start || adv;
  assign fire_hit  = adv && (|fire_vec);
  assign fire_task = 3'(scan_idx);

  // Command decode
  assign idx_ok  = ({29'd0, cmd.task_index} < 32'(TASK_COUNT));
  assign taken   = |(used_vec & hit_vec);
  assign slot_op = (cmd.opcode == OP_CREATE) || (cmd.opcode == OP_SUSPEND) ||
                   (cmd.opcode == OP_RESUME) || (cmd.opcode == OP_DELETE);

  assign cell_cmd.op      = cmd.opcode;
  assign cell_cmd.period  = cmd.period;
  assign cell_cmd.delay   = cmd.first_delay;
  assign cell_cmd.handler = cmd.handler_present;

  // Row of slot cells; the token enters at cell 0 on a tick
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    assign hit_vec[i] = ({29'd0, cmd.task_index} == 32'(i));
    assign en_vec[i]  = cmd_go && !is_tick && hit_vec[i];
    if (i == 0) begin : g_head
      assign chain_in[i] = start;
    end else begin : g_link
      assign chain_in[i] = token_vec[i-1];
    end
    ptts_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .token_prev (chain_in[i]),
      .token      (token_vec[i]),
      .cmd_en     (en_vec[i]),
      .cmd        (cell_cmd),
      .used       (used_vec[i]),
      .fire       (fire_vec[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (adv && token_vec[TASK_COUNT-1]) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result generation
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_go && !is_tick) begin
          out_load      = 1'b1;
          out_next.last = 1'b1;
          if (slot_op) begin
            if (!idx_ok) begin
              out_next.status = ST_RANGE;
            end else if (cmd.opcode == OP_CREATE && taken) begin
              out_next.status = ST_TAKEN;
            end else begin
              out_next.status = ST_OK;
            end
          end
        end
      end
      S_SCAN: begin
        // a new firing releases the previous one, which is not the last
        if (fire_hit && pend_valid) begin
          out_load            = 1'b1;
          out_next.fired      = 1'b1;
          out_next.fired_task = pend_idx;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_next.fired      = pend_valid;
          out_next.fired_task = pend_valid ? pend_idx : 3'd0;
          out_next.last       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan position and held firing
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      pend_valid <= 1'b0;
    end else if (start) begin
      scan_idx   <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (adv) scan_idx <= scan_idx + IW'(1);
      if (fire_hit) pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_hit) pend_idx <= fire_task;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (out_load) begin
      rpt_valid <= 1'b1;
    end else if (!rpt_stall) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rpt <= out_next;
  end

  // Checks
  `PTTS_ASSERT(a_token_single, clk, rst, $onehot0(token_vec), "more than one scan token")
  `PTTS_ASSERT_IMPL(a_token_scan, clk, rst, state == S_SCAN, token_vec[scan_idx],
    "scan token does not match scan index")
  `PTTS_ASSERT_IMPL(a_token_idle, clk, rst, state != S_SCAN, token_vec == '0,
    "scan token outside a tick")
  `PTTS_ASSERT_IMPL(a_nonlast_fired, clk, rst, rpt_valid && !rpt.last, rpt.fired,
    "non-final result without a firing")

endmodule
